// ===== rtl/core/pdts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdts_pkg
// Shared constants and types for the pass dependency ordering block.
// ----------------------------------------------------------------------------
package pdts_pkg;
  localparam int MaxPasses    = 32;
  localparam int NumResources = 32;
  localparam int MaskW        = 32;
  localparam int IdxW         = 5;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StCycle    = 2'd1;
  localparam logic [1:0] StOverflow = 2'd2;

  typedef enum logic [5:0] {
    S_LOAD  = 6'b000001,
    S_EDGE  = 6'b000010,
    S_SEED  = 6'b000100,
    S_POP   = 6'b001000,
    S_WALK  = 6'b010000,
    S_CLOSE = 6'b100000
  } state_t;
endpackage

// ===== rtl/core/pass_dependency_topo_sort.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pass_dependency_topo_sort
// Orders render passes by resource hazards using Kahn's algorithm.
// ----------------------------------------------------------------------------
// A non-final beat is stored and busy stays low. A final beat with N kept passes
// runs edge tests on all N*N pairs, seeds over the N passes, then per ordered pass
// one pop and a walk over the N passes, a last pop on an empty queue and a closing
// state; each result shows the cycle after its pop or closing state. One run at a
// time: busy is high from final beat to closing result; results cannot be stalled.
// Reset: synchronous, active low; clears control state, pass stores undefined.
module pass_dependency_topo_sort #(
  parameter int MAX_PASSES    = pdts_pkg::MaxPasses,
  parameter int NUM_RESOURCES = pdts_pkg::NumResources
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [pdts_pkg::MaskW-1:0] in_read_mask,
  input  logic [pdts_pkg::MaskW-1:0] in_write_mask,
  input  logic                     in_final_pass,
  output logic                     out_valid,
  output logic [pdts_pkg::IdxW-1:0] out_pass_index,
  output logic                     out_closing,
  output logic [1:0]               out_status
);
  localparam int PW = $clog2(MAX_PASSES);   // pass index width
  localparam int CW = $clog2(MAX_PASSES+1); // count width

  // Resource filter below NUM_RESOURCES.
  localparam logic [pdts_pkg::MaskW-1:0] RMask = (NUM_RESOURCES >= pdts_pkg::MaskW) ?
    {pdts_pkg::MaskW{1'b1}} :
    pdts_pkg::MaskW'((64'd1 << NUM_RESOURCES) - 64'd1);

  pdts_pkg::state_t state_r, state_nxt;

  logic [pdts_pkg::MaskW-1:0] rd_r  [MAX_PASSES];
  logic [pdts_pkg::MaskW-1:0] wr_r  [MAX_PASSES];
  logic [MAX_PASSES-1:0]      adj_r [MAX_PASSES];
  logic [CW-1:0]              deg_r [MAX_PASSES];
  logic [PW-1:0]              fifo_r[MAX_PASSES];

  logic [CW-1:0] cnt_r;
  logic          ovf_r;
  logic [PW-1:0] i_r, j_r, cur_r;
  logic [CW-1:0] head_r, tail_r, emit_r;

  logic acc;
  assign acc  = start && !busy;
  assign busy = (state_r != pdts_pkg::S_LOAD);

  // Shared compare unit: edge test for pair (i, j), one pair per cycle.
  logic edge_hit;
  always_comb begin
    edge_hit = 1'b0;
    if (i_r != j_r) begin
      edge_hit = |(wr_r[i_r] & rd_r[j_r]);
      if (i_r < j_r && |(wr_r[i_r] & wr_r[j_r])) edge_hit = 1'b1;
    end
  end

  logic last_i, last_j;
  assign last_i = (CW'(i_r) == cnt_r - CW'(1));
  assign last_j = (CW'(j_r) == cnt_r - CW'(1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pdts_pkg::S_LOAD:  if (acc && in_final_pass) state_nxt = pdts_pkg::S_EDGE;
      pdts_pkg::S_EDGE:  if (last_i && last_j) state_nxt = pdts_pkg::S_SEED;
      pdts_pkg::S_SEED:  if (last_i) state_nxt = pdts_pkg::S_POP;
      pdts_pkg::S_POP:   state_nxt = (head_r == tail_r) ? pdts_pkg::S_CLOSE
                                                        : pdts_pkg::S_WALK;
      pdts_pkg::S_WALK:  if (last_j) state_nxt = pdts_pkg::S_POP;
      pdts_pkg::S_CLOSE: state_nxt = pdts_pkg::S_LOAD;
      default:           state_nxt = pdts_pkg::S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pdts_pkg::S_LOAD;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      emit_r  <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= ((state_r == pdts_pkg::S_POP) && (head_r != tail_r)) ||
                   (state_r == pdts_pkg::S_CLOSE);
      case (state_r)
        pdts_pkg::S_LOAD: begin
          i_r <= '0;
          j_r <= '0;
          head_r <= '0;
          tail_r <= '0;
          emit_r <= '0;
          if (acc) begin
            if (cnt_r < CW'(MAX_PASSES)) cnt_r <= cnt_r + CW'(1);
            else ovf_r <= 1'b1;
          end
        end
        pdts_pkg::S_EDGE: begin
          if (last_j) begin
            j_r <= '0;
            i_r <= last_i ? '0 : i_r + PW'(1);
          end else begin
            j_r <= j_r + PW'(1);
          end
        end
        pdts_pkg::S_SEED: begin
          if (deg_r[i_r] == '0) tail_r <= tail_r + CW'(1);
          i_r <= i_r + PW'(1);
        end
        pdts_pkg::S_POP: begin
          j_r <= '0;
          if (head_r != tail_r) begin
            head_r <= head_r + CW'(1);
            emit_r <= emit_r + CW'(1);
          end
        end
        pdts_pkg::S_WALK: begin
          if (adj_r[cur_r][j_r] && deg_r[j_r] == CW'(1)) tail_r <= tail_r + CW'(1);
          j_r <= j_r + PW'(1);
        end
        pdts_pkg::S_CLOSE: begin
          cnt_r <= '0;
          ovf_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Payload and store updates.
  always_ff @(posedge clk) begin
    case (state_r)
      pdts_pkg::S_LOAD: begin
        if (acc && cnt_r < CW'(MAX_PASSES)) begin
          rd_r[PW'(cnt_r)] <= in_read_mask & RMask;
          wr_r[PW'(cnt_r)] <= in_write_mask & RMask;
        end
        for (int k = 0; k < MAX_PASSES; k++) begin
          deg_r[k] <= '0;
          adj_r[k] <= '0;
        end
      end
      pdts_pkg::S_EDGE: if (edge_hit) begin
        adj_r[i_r][j_r] <= 1'b1;
        deg_r[j_r] <= deg_r[j_r] + CW'(1);
      end
      pdts_pkg::S_SEED: if (deg_r[i_r] == '0) fifo_r[PW'(tail_r)] <= i_r;
      pdts_pkg::S_POP: begin
        cur_r <= fifo_r[PW'(head_r)];
        out_pass_index <= pdts_pkg::IdxW'(fifo_r[PW'(head_r)]);
        out_closing <= 1'b0;
        out_status  <= pdts_pkg::StOk;
      end
      pdts_pkg::S_WALK: if (adj_r[cur_r][j_r]) begin
        deg_r[j_r] <= deg_r[j_r] - CW'(1);
        if (deg_r[j_r] == CW'(1)) fifo_r[PW'(tail_r)] <= j_r;
      end
      pdts_pkg::S_CLOSE: begin
        out_pass_index <= '0;
        out_closing <= 1'b1;
        out_status <= ovf_r ? pdts_pkg::StOverflow :
                      (emit_r != cnt_r) ? pdts_pkg::StCycle : pdts_pkg::StOk;
      end
      default: ;
    endcase
  end

  a_close_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pdts_pkg::S_CLOSE) |=>
      (state_r == pdts_pkg::S_LOAD && out_valid && out_closing))
    else $error("closing result missing");
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r) else $error("fifo underflow");
  a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pdts_pkg::S_LOAD && !$past(state_r == pdts_pkg::S_POP)
     && !$past(state_r == pdts_pkg::S_CLOSE)) |-> !out_valid)
    else $error("result while loading");
endmodule

// ===== sim/tb_pass_dependency_topo_sort.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pass_dependency_topo_sort
// Self-checking bench for the pass ordering block. Graphs of passes are sent
// as beats. A behavioral Kahn sort predicts the execution order and the
// closing status, and every result beat is compared against that prediction.
// ----------------------------------------------------------------------------
module tb_pass_dependency_topo_sort;

  // A result beat as the block presents it.
  typedef struct packed {
    logic [pdts_pkg::IdxW-1:0] idx;
    logic                      closing;
    logic [1:0]                status;
  } order_beat_t;

  // One row of the directed table. When has_close is set, the status of the
  // closing beat is typed in and is checked against the predictor as well.
  typedef struct packed {
    logic [pdts_pkg::MaskW-1:0] rd;
    logic [pdts_pkg::MaskW-1:0] wr;
    logic                       fin;
    logic                       has_close;
    logic [1:0]                 close_status;
  } stim_row_t;

  localparam int NumRows = 24;
  localparam int WatchdogLimit = 40000;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic [pdts_pkg::MaskW-1:0] in_read_mask;
  logic [pdts_pkg::MaskW-1:0] in_write_mask;
  logic                       in_final_pass;
  logic                       out_valid;
  logic [pdts_pkg::IdxW-1:0]  out_pass_index;
  logic                       out_closing;
  logic [1:0]                 out_status;

  // Predictor state: the passes of the graph that is being collected.
  logic [pdts_pkg::MaskW-1:0] graph_reads[pdts_pkg::MaxPasses];
  logic [pdts_pkg::MaskW-1:0] graph_writes[pdts_pkg::MaxPasses];
  int                         graph_size;
  bit                         graph_overflow;

  order_beat_t expected_order[$];
  stim_row_t   directed_rows[NumRows];

  int  errors;
  int  beats_sent;
  int  results_seen;
  int  graphs_sent;
  int  idle_cycles;
  int  sender_idle_pct;

  pass_dependency_topo_sort uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_read_mask  (in_read_mask),
    .in_write_mask (in_write_mask),
    .in_final_pass (in_final_pass),
    .out_valid     (out_valid),
    .out_pass_index(out_pass_index),
    .out_closing   (out_closing),
    .out_status    (out_status)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Store one pass; on the final one run Kahn's sort and queue the result
  // beats it yields, the closing beat last.
  task automatic predict_order(input logic [pdts_pkg::MaskW-1:0] rd,
                               input logic [pdts_pkg::MaskW-1:0] wr,
                               input logic fin);
    logic [pdts_pkg::MaxPasses-1:0] succ[pdts_pkg::MaxPasses];
    int                             indeg[pdts_pkg::MaxPasses];
    int                             ready[$];
    int                             cur;
    int                             ordered;
    order_beat_t                    b;
    if (graph_size < pdts_pkg::MaxPasses) begin
      graph_reads[graph_size]  = rd;
      graph_writes[graph_size] = wr;
      graph_size++;
    end else begin
      graph_overflow = 1'b1;
    end
    if (!fin) return;
    for (int i = 0; i < graph_size; i++) begin
      succ[i]  = '0;
      indeg[i] = 0;
    end
    for (int i = 0; i < graph_size; i++) begin
      for (int j = 0; j < graph_size; j++) begin
        if (i != j && ((graph_writes[i] & graph_reads[j]) != 0 ||
                       (i < j && (graph_writes[i] & graph_writes[j]) != 0))) begin
          succ[i][j] = 1'b1;
          indeg[j]++;
        end
      end
    end
    for (int i = 0; i < graph_size; i++)
      if (indeg[i] == 0) ready = {ready, i};
    ordered = 0;
    while (ready.size() > 0) begin
      cur = ready.pop_front();
      b.idx = cur[pdts_pkg::IdxW-1:0];
      b.closing = 1'b0;
      b.status = pdts_pkg::StOk;
      expected_order = {expected_order, b};
      ordered++;
      for (int j = 0; j < graph_size; j++) begin
        if (succ[cur][j]) begin
          indeg[j]--;
          if (indeg[j] == 0) ready = {ready, j};
        end
      end
    end
    b.idx = '0;
    b.closing = 1'b1;
    if (graph_overflow) b.status = pdts_pkg::StOverflow;
    else if (ordered != graph_size) b.status = pdts_pkg::StCycle;
    else b.status = pdts_pkg::StOk;
    expected_order = {expected_order, b};
    graph_size = 0;
    graph_overflow = 1'b0;
    graphs_sent++;
  endtask

  // Drive one beat and hold it until the block takes it. Idle cycles are
  // inserted ahead of the beat according to the current sender setting.
  // Start stays high after the beat; the next idle cycle or drain drops it.
  task automatic send_pass(input logic [pdts_pkg::MaskW-1:0] rd,
                           input logic [pdts_pkg::MaskW-1:0] wr,
                           input logic fin);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_read_mask  <= rd;
    in_write_mask <= wr;
    in_final_pass <= fin;
    @(posedge clk);
    while (busy) @(posedge clk);
    // The beat was taken at this edge.
    predict_order(rd, wr, fin);
    beats_sent++;
  endtask

  // Random graph: mostly small with sparse masks over few resources so that
  // both orderable graphs and cycles show up; now and then a full-width or
  // oversize graph.
  task automatic send_random_graph();
    int          n;
    int          sel;
    logic [31:0] span;
    logic [31:0] rd;
    logic [31:0] wr;
    sel = $urandom_range(99);
    if (sel < 6) n = $urandom_range(pdts_pkg::MaxPasses + 3, pdts_pkg::MaxPasses - 1);
    else if (sel < 12) n = 1;
    else n = $urandom_range(8, 2);
    span = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : 32'h0000_00FF;
    for (int p = 0; p < n; p++) begin
      rd = $urandom() & $urandom() & span;
      wr = $urandom() & $urandom() & $urandom() & span;
      if ($urandom_range(9) == 0) rd = $urandom();
      if ($urandom_range(9) == 0) wr = $urandom();
      send_pass(rd, wr, p == n - 1);
    end
  endtask

  task automatic wait_for_drain();
    start <= 1'b0;
    while (expected_order.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Results are sampled at the rising edge, while the inputs change only
  // through nonblocking assignments at that same edge.
  always @(posedge clk) begin
    order_beat_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (expected_order.size() == 0) begin
        $display("%0t: unexpected result beat idx=%0d closing=%0b status=%0d",
                 $time, out_pass_index, out_closing, out_status);
        errors++;
      end else begin
        want = expected_order.pop_front();
        if (out_closing !== want.closing) begin
          $display("%0t: closing mismatch: expected %0b, actual %0b",
                   $time, want.closing, out_closing);
          errors++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, out_status);
          errors++;
        end
        // The index carries no meaning on the closing beat.
        if (!want.closing && out_pass_index !== want.idx) begin
          $display("%0t: pass index mismatch: expected %0d, actual %0d",
                   $time, want.idx, out_pass_index);
          errors++;
        end
      end
    end
  end

  // Watchdog: any accepted beat or result restarts the count.
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time,
                 expected_order.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    // Directed graphs. Closing statuses are typed in where they are obvious.
    directed_rows[0]  = '{32'h0, 32'h0, 1'b1, 1'b1, pdts_pkg::StOk};   // lone empty pass
    directed_rows[1]  = '{32'h1, 32'h0, 1'b0, 1'b0, pdts_pkg::StOk};   // read after write
    directed_rows[2]  = '{32'h0, 32'h1, 1'b1, 1'b1, pdts_pkg::StOk};
    directed_rows[3]  = '{32'h2, 32'h1, 1'b0, 1'b0, pdts_pkg::StOk};   // two-pass cycle
    directed_rows[4]  = '{32'h1, 32'h2, 1'b1, 1'b1, pdts_pkg::StCycle};
    directed_rows[5]  = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, pdts_pkg::StOk};
    directed_rows[6]  = '{32'h0, 32'hFFFF_FFFF, 1'b1, 1'b1, pdts_pkg::StCycle}; // all ones
    directed_rows[7]  = '{32'h0, 32'h8000_0000, 1'b0, 1'b0, pdts_pkg::StOk}; // write after write
    directed_rows[8]  = '{32'h0, 32'h8000_0000, 1'b0, 1'b0, pdts_pkg::StOk};
    directed_rows[9]  = '{32'h8000_0000, 32'h0, 1'b1, 1'b1, pdts_pkg::StOk};
    directed_rows[10] = '{32'h4, 32'h4, 1'b1, 1'b1, pdts_pkg::StOk};   // self read-write
    directed_rows[11] = '{32'h0, 32'h0, 1'b0, 1'b0, pdts_pkg::StOk};   // independent passes
    directed_rows[12] = '{32'h5555_5555, 32'h0, 1'b0, 1'b0, pdts_pkg::StOk};
    directed_rows[13] = '{32'hAAAA_AAAA, 32'h0, 1'b1, 1'b1, pdts_pkg::StOk};
    directed_rows[14] = '{32'h0, 32'h10, 1'b0, 1'b0, pdts_pkg::StOk};  // chain behind a cycle
    directed_rows[15] = '{32'h30, 32'h20, 1'b0, 1'b0, pdts_pkg::StOk};
    directed_rows[16] = '{32'h20, 32'h10, 1'b0, 1'b0, pdts_pkg::StOk};
    directed_rows[17] = '{32'h10, 32'h0, 1'b1, 1'b1, pdts_pkg::StCycle};
    directed_rows[18] = '{32'hF0F0_F0F0, 32'h0F0F_0F0F, 1'b0, 1'b0, pdts_pkg::StOk};
    directed_rows[19] = '{32'h0F0F_0F0F, 32'h0, 1'b0, 1'b0, pdts_pkg::StOk};
    directed_rows[20] = '{32'h0, 32'hF0F0_F0F0, 1'b1, 1'b0, pdts_pkg::StOk};
    directed_rows[21] = '{32'h1, 32'h1, 1'b0, 1'b0, pdts_pkg::StOk};
    directed_rows[22] = '{32'h2, 32'h1, 1'b0, 1'b0, pdts_pkg::StOk};
    directed_rows[23] = '{32'h1, 32'h2, 1'b1, 1'b1, pdts_pkg::StCycle};

    errors = 0;
    beats_sent = 0;
    results_seen = 0;
    graphs_sent = 0;
    graph_size = 0;
    graph_overflow = 1'b0;
    sender_idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_read_mask = '0;
    in_write_mask = '0;
    in_final_pass = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      send_pass(directed_rows[r].rd, directed_rows[r].wr, directed_rows[r].fin);
      if (directed_rows[r].has_close &&
          expected_order[$].status !== directed_rows[r].close_status) begin
        $display("%0t: row %0d closing status: expected %0d, predicted %0d", $time, r,
                 directed_rows[r].close_status, expected_order[$].status);
        errors++;
      end
    end

    // Overflow: a full graph plus two extra passes, both dropped, the last one final.
    for (int p = 0; p < pdts_pkg::MaxPasses + 2; p++)
      send_pass(32'h0, 32'h1 << (p % 32), p == pdts_pkg::MaxPasses + 1);
    if (expected_order[$].status !== pdts_pkg::StOverflow) begin
      $display("%0t: overflow closing: expected %0d, predicted %0d", $time,
               pdts_pkg::StOverflow, expected_order[$].status);
      errors++;
    end

    // The sender holds off until every outstanding result has arrived.
    wait_for_drain();

    // Random part across sender idling phases.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: sender_idle_pct = 0;
        1: sender_idle_pct = 73;
        2: sender_idle_pct = 32;
        default: sender_idle_pct = 0;
      endcase
      while (beats_sent < 58 + 80 * (ph + 1)) send_random_graph();
      if (ph == 1) wait_for_drain();
    end

    wait_for_drain();
    repeat (40) @(posedge clk);

    $display("Covered %0d pass beats in %0d graphs, %0d result beats checked.",
             beats_sent, graphs_sent, results_seen);
    $display("Graphs included orderable sets, cycles and overflowed sets.");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
